FILE: rtl/mersenne_twister_rng_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the twister generator
// Macros that check invariants on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef MERSENNE_TWISTER_RNG_ASSERT_SVH
`define MERSENNE_TWISTER_RNG_ASSERT_SVH

`ifndef NO_ASSERTIONS
// A condition that holds at every clock edge out of reset.
`define MTR_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("invariant violated");
// A cause that must be followed by an effect in the next cycle.
`define MTR_ASSERT_NEXT(label, cause, effect) \
  label: assert property (@(posedge clk) disable iff (rst) (cause) |=> (effect)) \
    else $error("sequence violated");
`else
`define MTR_ASSERT_ALWAYS(label, cond)
`define MTR_ASSERT_NEXT(label, cause, effect)
`endif

`endif

FILE: rtl/mtr_pkg.sv
// ----------------------------------------------------------------------------
// Twister generator package
// Shared constants, types and word functions of the generator.
// ----------------------------------------------------------------------------
package mtr_pkg;

  localparam int unsigned WORDS     = 624;
  localparam int unsigned SHIFT_M   = 397;
  localparam int unsigned ADDR_W    = 10;

  localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(WORDS - 1);
  localparam logic [ADDR_W-1:0] END_ADDR   = ADDR_W'(WORDS);
  localparam logic [ADDR_W-1:0] WRAP_POINT = ADDR_W'(WORDS - SHIFT_M);
  localparam logic [ADDR_W-1:0] FAR_OFFSET = ADDR_W'(SHIFT_M);

  localparam logic [31:0] TWIST_A    = 32'h9908b0df;
  localparam logic [31:0] HI_BIT     = 32'h80000000;
  localparam logic [31:0] LO_BITS    = 32'h7fffffff;
  localparam logic [31:0] TEMPER_B   = 32'h9d2c5680;
  localparam logic [31:0] TEMPER_C   = 32'hefc60000;
  localparam logic [31:0] SEED_MULT  = 32'd1812433253;

  // Request kinds.
  localparam logic [1:0] REQ_DRAW32 = 2'd0;
  localparam logic [1:0] REQ_DRAW53 = 2'd1;
  localparam logic [1:0] REQ_SEED   = 2'd2;
  localparam logic [1:0] REQ_JUMP   = 2'd3;

  // Result status codes.
  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_UNSEEDED = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SEED_WR,
    ST_SEED_MUL,
    ST_DRAW_RD,
    ST_DRAW_DAT,
    ST_GEN_R0,
    ST_GEN_R1,
    ST_GEN_R2,
    ST_GEN_W,
    ST_JMP_DIV,
    ST_JMP_RI,
    ST_JMP_RJ,
    ST_JMP_WI,
    ST_JMP_WJ,
    ST_ADD_RD,
    ST_ADD_WR,
    ST_DONE
  } state_t;

  // Write port of the state store.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [31:0]       data;
  } store_wr_t;

  // One twist step from the upper bit, lower bits and far word.
  function automatic logic [31:0] mix_pair(input logic [31:0] hi_src,
                                           input logic [31:0] lo_src,
                                           input logic [31:0] far);
    logic [31:0] y;
    y = (hi_src & HI_BIT) | (lo_src & LO_BITS);
    return far ^ (y >> 1) ^ (y[0] ? TWIST_A : 32'd0);
  endfunction

  // Output tempering of one store word.
  function automatic logic [31:0] temper(input logic [31:0] w);
    logic [31:0] y;
    y = w ^ (w >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

FILE: rtl/mersenne_twister_rng.sv
// ----------------------------------------------------------------------------
// Twister generator top level
// Seeds, draws, 53-bit draws and jumps over a 624-word state store.
//
//   channel  dir  tdata                          tuser
//   s_axis   in   seed_value[31:0] jump_count    req_type[1:0]
//   m_axis   out  value[52:0]                    status[0]
//
// One item is worked on at a time; each gives one result item.
// A draw reads a store word, tempers it and registers the result; a 53-bit
// draw reads two words; the input is ready again as the result is registered.
// A draw that finds the store used up first twists it, word by word, with
// three reads and a write. A seed runs the multiplier, then the add and write,
// per word. A jump runs a bit-serial remainder and a swap per word over 622
// words, then an add pass. Reset is synchronous; the store needs
// no clearing since requests before a seed never read it. A stalled result
// holds the sequencer in its last state; the input side is then not ready.
// ----------------------------------------------------------------------------
module mersenne_twister_rng (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // seed_value[31:0], jump_count[62:32], zero
  input  logic [1:0]  s_axis_tuser,   // req_type[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // value[52:0], zero
  output logic [0:0]  m_axis_tuser    // status[0]
);

  localparam int unsigned AW = mtr_pkg::ADDR_W;

  mtr_pkg::state_t state, state_next;

  logic [AW-1:0] k;
  logic [AW-1:0] idx;
  logic          seeded;
  logic          second;
  logic [26:0]   acc_a;
  logic [31:0]   w;
  logic [31:0]   prod;
  logic [31:0]   wa;
  logic [31:0]   wb;
  logic [30:0]   n;
  logic [AW-1:0] rem;
  logic [4:0]    bitcnt;
  logic [31:0]   wi;
  logic          res_status;

  mtr_pkg::store_wr_t wr;
  logic [AW-1:0]      raddr;
  logic [31:0]        rdata;

  logic          s_fire;
  logic          out_free;
  logic [AW-1:0] k_nxt;
  logic [AW-1:0] k_far;
  logic [31:0]   seed_word;
  logic [31:0]   y_temp;
  logic [AW:0]   rem_trial;
  logic [AW:0]   rem_diff;

  assign s_fire   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = (state == mtr_pkg::ST_IDLE);

  // Neighbor addresses for the twist.
  assign k_nxt = (k == mtr_pkg::LAST_ADDR) ? '0 : k + AW'(1);
  assign k_far = (k < mtr_pkg::WRAP_POINT) ? k + mtr_pkg::FAR_OFFSET
                                           : k - mtr_pkg::WRAP_POINT;

  // First seed word is the seed itself, later ones add the index.
  assign seed_word = (k == '0) ? w : prod + {{(32-AW){1'b0}}, k};
  assign y_temp    = mtr_pkg::temper(rdata);

  // One remainder bit per cycle.
  assign rem_trial = {rem, n[bitcnt]};
  assign rem_diff  = rem_trial - {1'b0, k};

  mtr_store u_store (
    .clk   (clk),
    .wr    (wr),
    .raddr (raddr),
    .rdata (rdata)
  );

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mtr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and store control.
  always_comb begin
    state_next = state;
    wr         = '{we: 1'b0, addr: k, data: seed_word};
    raddr      = k;
    case (state)
      mtr_pkg::ST_IDLE: begin
        if (s_fire) begin
          if (s_axis_tuser == mtr_pkg::REQ_SEED) begin
            state_next = mtr_pkg::ST_SEED_WR;
          end else if (!seeded) begin
            state_next = mtr_pkg::ST_DONE;
          end else if (s_axis_tuser == mtr_pkg::REQ_JUMP) begin
            state_next = mtr_pkg::ST_JMP_DIV;
          end else begin
            state_next = mtr_pkg::ST_DRAW_RD;
          end
        end
      end
      mtr_pkg::ST_SEED_WR: begin
        wr.we = 1'b1;
        state_next = (k == mtr_pkg::LAST_ADDR) ? mtr_pkg::ST_DONE : mtr_pkg::ST_SEED_MUL;
      end
      mtr_pkg::ST_SEED_MUL: begin
        state_next = mtr_pkg::ST_SEED_WR;
      end
      mtr_pkg::ST_DRAW_RD: begin
        raddr = idx;
        state_next = (idx >= mtr_pkg::END_ADDR) ? mtr_pkg::ST_GEN_R0 : mtr_pkg::ST_DRAW_DAT;
      end
      mtr_pkg::ST_DRAW_DAT: begin
        state_next = second ? mtr_pkg::ST_DRAW_RD : mtr_pkg::ST_DONE;
      end
      mtr_pkg::ST_GEN_R0: begin
        state_next = mtr_pkg::ST_GEN_R1;
      end
      mtr_pkg::ST_GEN_R1: begin
        raddr = k_nxt;
        state_next = mtr_pkg::ST_GEN_R2;
      end
      mtr_pkg::ST_GEN_R2: begin
        raddr = k_far;
        state_next = mtr_pkg::ST_GEN_W;
      end
      mtr_pkg::ST_GEN_W: begin
        wr = '{we: 1'b1, addr: k, data: mtr_pkg::mix_pair(wa, wb, rdata)};
        state_next = (k == mtr_pkg::LAST_ADDR) ? mtr_pkg::ST_DRAW_RD : mtr_pkg::ST_GEN_R0;
      end
      mtr_pkg::ST_JMP_DIV: begin
        state_next = (bitcnt == '0) ? mtr_pkg::ST_JMP_RI : mtr_pkg::ST_JMP_DIV;
      end
      mtr_pkg::ST_JMP_RI: begin
        state_next = mtr_pkg::ST_JMP_RJ;
      end
      mtr_pkg::ST_JMP_RJ: begin
        raddr = rem;
        state_next = mtr_pkg::ST_JMP_WI;
      end
      mtr_pkg::ST_JMP_WI: begin
        wr = '{we: 1'b1, addr: k, data: rdata};
        state_next = mtr_pkg::ST_JMP_WJ;
      end
      mtr_pkg::ST_JMP_WJ: begin
        wr = '{we: 1'b1, addr: rem, data: wi};
        state_next = (k == AW'(2)) ? mtr_pkg::ST_ADD_RD : mtr_pkg::ST_JMP_DIV;
      end
      mtr_pkg::ST_ADD_RD: begin
        state_next = mtr_pkg::ST_ADD_WR;
      end
      mtr_pkg::ST_ADD_WR: begin
        wr = '{we: 1'b1, addr: k, data: rdata + {{(32-AW){1'b0}}, k} + 32'd1};
        state_next = (k == mtr_pkg::LAST_ADDR) ? mtr_pkg::ST_DONE : mtr_pkg::ST_ADD_RD;
      end
      mtr_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = mtr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mtr_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers: read index and seeded mark.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx    <= mtr_pkg::END_ADDR;
      seeded <= 1'b0;
    end else begin
      case (state)
        mtr_pkg::ST_SEED_WR: begin
          if (k == mtr_pkg::LAST_ADDR) begin
            idx    <= mtr_pkg::END_ADDR;
            seeded <= 1'b1;
          end
        end
        mtr_pkg::ST_GEN_W: begin
          if (k == mtr_pkg::LAST_ADDR) begin
            idx <= '0;
          end
        end
        mtr_pkg::ST_DRAW_DAT: begin
          idx <= idx + AW'(1);
        end
        mtr_pkg::ST_ADD_WR: begin
          idx <= mtr_pkg::END_ADDR;
        end
        default: begin
        end
      endcase
    end
  end

  // Datapath registers stepped by the sequencer.
  always_ff @(posedge clk) begin
    case (state)
      mtr_pkg::ST_IDLE: begin
        if (s_fire) begin
          w          <= s_axis_tdata[31:0];
          n          <= s_axis_tdata[62:32];
          second     <= (s_axis_tuser == mtr_pkg::REQ_DRAW53);
          res_status <= mtr_pkg::STATUS_OK;
          rem        <= '0;
          bitcnt     <= 5'd30;
          k          <= (s_axis_tuser == mtr_pkg::REQ_JUMP) ? mtr_pkg::LAST_ADDR : '0;
          if (s_axis_tuser != mtr_pkg::REQ_SEED && !seeded) begin
            res_status <= mtr_pkg::STATUS_UNSEEDED;
          end
        end
      end
      mtr_pkg::ST_SEED_WR: begin
        w <= seed_word;
      end
      mtr_pkg::ST_SEED_MUL: begin
        prod <= (w ^ (w >> 30)) * mtr_pkg::SEED_MULT;
        k    <= k + AW'(1);
      end
      mtr_pkg::ST_DRAW_RD: begin
        if (idx >= mtr_pkg::END_ADDR) begin
          k <= '0;
        end
      end
      mtr_pkg::ST_DRAW_DAT: begin
        if (second) begin
          acc_a  <= y_temp[31:5];
          second <= 1'b0;
        end
      end
      mtr_pkg::ST_GEN_R1: begin
        wa <= rdata;
      end
      mtr_pkg::ST_GEN_R2: begin
        wb <= rdata;
      end
      mtr_pkg::ST_GEN_W: begin
        k <= k_nxt;
      end
      mtr_pkg::ST_JMP_DIV: begin
        rem    <= (rem_trial >= {1'b0, k}) ? rem_diff[AW-1:0] : rem_trial[AW-1:0];
        bitcnt <= bitcnt - 5'd1;
      end
      mtr_pkg::ST_JMP_RJ: begin
        wi <= rdata;
      end
      mtr_pkg::ST_JMP_WJ: begin
        rem    <= '0;
        bitcnt <= 5'd30;
        k      <= (k == AW'(2)) ? '0 : k - AW'(1);
      end
      mtr_pkg::ST_ADD_WR: begin
        k <= k + AW'(1);
      end
      default: begin
      end
    endcase
  end

  logic        two_words;
  logic [52:0] merged;

  // Kind of the draw in flight, kept from acceptance.
  always_ff @(posedge clk) begin
    if (state == mtr_pkg::ST_IDLE && s_fire) begin
      two_words <= (s_axis_tuser == mtr_pkg::REQ_DRAW53);
    end
  end

  assign merged = two_words ? {acc_a, y_temp[31:6]} : {21'd0, y_temp};

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == mtr_pkg::ST_DONE && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  logic [52:0] draw_value;

  // Draw result captured when the last word is tempered.
  always_ff @(posedge clk) begin
    if (state == mtr_pkg::ST_IDLE && s_fire) begin
      draw_value <= '0;
    end else if (state == mtr_pkg::ST_DRAW_DAT && !second) begin
      draw_value <= merged;
    end
  end

  always_ff @(posedge clk) begin
    if (state == mtr_pkg::ST_DONE && out_free) begin
      m_axis_tdata <= {3'd0, draw_value};
      m_axis_tuser <= res_status;
    end
  end

  // Last word of a twist pass is being written.
  logic gen_last;
  assign gen_last = (state == mtr_pkg::ST_GEN_W) && (k == mtr_pkg::LAST_ADDR);

  `include "mersenne_twister_rng_assert.svh"

  `MTR_ASSERT_ALWAYS(a_idx_range, idx <= mtr_pkg::END_ADDR)
  `MTR_ASSERT_ALWAYS(a_rem_below_i, (state != mtr_pkg::ST_JMP_RI) || (rem < k))
  `MTR_ASSERT_NEXT(a_twist_resets_idx, gen_last, idx == '0)

endmodule

FILE: rtl/mtr_store.sv
// ----------------------------------------------------------------------------
// Twister state store
// Single-clock memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module mtr_store (
  input  logic                         clk,
  input  mtr_pkg::store_wr_t           wr,
  input  logic [mtr_pkg::ADDR_W-1:0]   raddr,
  output logic [31:0]                  rdata
);

  logic [31:0] mem [mtr_pkg::WORDS];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Read port, registered.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
